[design/jcss_pkg.sv]
// ----------------------------------------------------------------------------
// jcss_pkg
// shared constants, codes and types of the chain scan sequencer
// ----------------------------------------------------------------------------
package jcss_pkg;

  localparam int unsigned MaxDevices  = 16;
  localparam int unsigned MaxIrLength = 32;
  localparam int unsigned DevW        = $clog2(MaxDevices);
  localparam int unsigned SumW        = 9;

  localparam logic [2:0] CmdReset  = 3'd0;
  localparam logic [2:0] CmdLoad   = 3'd1;
  localparam logic [2:0] CmdSelect = 3'd2;
  localparam logic [2:0] CmdWrIr   = 3'd3;
  localparam logic [2:0] CmdDr     = 3'd4;

  localparam logic [1:0] KindTrst  = 2'd0;
  localparam logic [1:0] KindTms   = 2'd1;
  localparam logic [1:0] KindShift = 2'd2;

  localparam logic [31:0] BypassIr = 32'hffff_ffff;

  // table port request from sequencer to table memory
  typedef struct packed {
    logic            wr_en;
    logic [DevW-1:0] addr;
    logic [5:0]      wdata;
  } tbl_req_t;

endpackage

[design/jcss_ir_table.sv]
// ----------------------------------------------------------------------------
// jcss_ir_table
// per-device ir length memory, one port, registered read data
// ----------------------------------------------------------------------------
module jcss_ir_table (
  input  logic               clk_i,
  input  jcss_pkg::tbl_req_t req_i,
  output logic [5:0]         rdata_o
);

  logic [5:0] mem_q [jcss_pkg::MaxDevices];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.addr];
  end

endmodule

[design/jtag_chain_scan_sequencer.sv]
// ----------------------------------------------------------------------------
// jtag_chain_scan_sequencer
// turns chain commands into trst, tms and shift segments for a tap shifter
// ----------------------------------------------------------------------------
// usage:
// - s_axis carries one command word: tuser = cmd, tlast = last_word, tdata =
//   device, ir_length, value, word_bits, first_word from the low bit up
// - m_axis carries segment words: tuser = seg_kind, tlast marks the last
//   segment of a command, tdata = seg_bits, seg_data, seg_exit, capture_tdo
// - cfg port writes device_count (index 0) and the idle clock count (index 1)
// - one command at a time: tready is low while a command is in work and
//   until its last segment has left the output register
// - each segment is formed and waits in the output register
// - select walks the ir length memory one entry a cycle, up to the
//   effective device_count
// - a stalled receiver holds the segment
// - after reset no device is selected, the instruction is bypass and the
//   ir length memory keeps its unknown contents until loaded
// ----------------------------------------------------------------------------
module jtag_chain_scan_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // device, ir_length, value, word_bits, first_word, pad
  input  logic [55:0] s_axis_tdata,
  // cmd
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seg_bits, seg_data, seg_exit, capture_tdo
  output logic [39:0] m_axis_tdata,
  // seg_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_wdata_i
);

  typedef enum logic [3:0] {
    StIdle, StSelRd, StSelSum, StTms, StPre, StTgt, StPost, StExit, StIdleClk,
    StDrHead, StDrPad, StDrData, StDrTail, StTrst
  } state_e;

  localparam int unsigned DevW = jcss_pkg::DevW;
  localparam int unsigned SumW = jcss_pkg::SumW;

  state_e       state_q;
  logic [4:0]   dev_cnt_q;
  logic [5:0]   idle_q;
  logic         dev_valid_q;
  logic [DevW-1:0] sel_dev_q, cmd_dev_q, walk_q;
  logic [31:0]  cur_ir_q, val_q;
  logic [5:0]   sel_len_q, wbits_q;
  logic [SumW-1:0] before_q, after_q, rem_q;
  logic         last_q;
  logic         rd_pend_q;
  logic         ov_q;
  logic [1:0]   o_kind_q;
  logic [5:0]   o_bits_q;
  logic [31:0]  o_data_q;
  logic         o_exit_q, o_cap_q, o_last_q;

  jcss_pkg::tbl_req_t req;
  logic [5:0]         rdata;

  // input fields
  logic [2:0]  in_cmd;
  logic [3:0]  in_dev;
  logic [5:0]  in_irl;
  logic [31:0] in_val;
  logic [5:0]  in_wb;
  logic        in_first, in_last;
  assign in_cmd   = s_axis_tuser;
  assign in_dev   = s_axis_tdata[3:0];
  assign in_irl   = s_axis_tdata[9:4];
  assign in_val   = s_axis_tdata[41:10];
  assign in_wb    = s_axis_tdata[47:42];
  assign in_first = s_axis_tdata[48];
  assign in_last  = s_axis_tlast;

  logic [4:0] cnt_eff;
  assign cnt_eff = (dev_cnt_q > 5'(jcss_pkg::MaxDevices)) ?
                   5'(jcss_pkg::MaxDevices) : dev_cnt_q;
  logic [5:0] idle_eff;
  assign idle_eff = (idle_q > 6'd32) ? 6'd32 : idle_q;

  logic busy;
  assign busy = (state_q != StIdle);
  assign s_axis_tready = !busy && !ov_q;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  // output slot free for a new segment
  logic room;
  assign room = !ov_q || m_axis_tready;

  // a segment is formed this cycle
  logic seg_load;
  always_comb begin
    seg_load = 1'b0;
    if (room) begin
      case (state_q)
        StTrst, StTms, StTgt, StExit, StIdleClk, StDrHead, StDrData: seg_load = 1'b1;
        StPre, StPost, StDrTail, StDrPad: seg_load = (rem_q != '0);
        default: seg_load = 1'b0;
      endcase
    end
  end

  logic [5:0] irl_sat;
  assign irl_sat = (in_irl == 6'd0) ? 6'd1 : (in_irl > 6'd32 ? 6'd32 : in_irl);

  always_comb begin
    req.wr_en = acc && (in_cmd == jcss_pkg::CmdLoad);
    req.addr  = acc ? DevW'(in_dev) : walk_q;
    req.wdata = irl_sat;
  end

  jcss_ir_table u_tbl (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  logic tail_dev;
  assign tail_dev = (5'(sel_dev_q) + 5'd1) >= cnt_eff;
  logic [5:0] chunk;
  assign chunk = (rem_q > SumW'(32)) ? 6'd32 : 6'(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      dev_cnt_q   <= 5'd1;
      idle_q      <= 6'd0;
      dev_valid_q <= 1'b0;
      sel_dev_q   <= '0;
      cur_ir_q    <= jcss_pkg::BypassIr;
      sel_len_q   <= '0;
      before_q    <= '0;
      after_q     <= '0;
      ov_q        <= 1'b0;
      rd_pend_q   <= 1'b0;
      cmd_dev_q   <= '0;
      walk_q      <= '0;
      val_q       <= '0;
      wbits_q     <= '0;
      rem_q       <= '0;
      last_q      <= 1'b0;
      o_kind_q    <= '0;
      o_bits_q    <= '0;
      o_data_q    <= '0;
      o_exit_q    <= 1'b0;
      o_cap_q     <= 1'b0;
      o_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (!cfg_index_i) dev_cnt_q <= cfg_wdata_i[4:0];
        else idle_q <= cfg_wdata_i;
      end
      if (seg_load) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (acc) begin
        val_q     <= in_val;
        cmd_dev_q <= DevW'(in_dev);
        last_q    <= in_last;
        wbits_q   <= (in_wb == 6'd0) ? 6'd1 : (in_wb > 6'd32 ? 6'd32 : in_wb);
        case (in_cmd)
          jcss_pkg::CmdReset: state_q <= StTrst;
          jcss_pkg::CmdSelect: begin
            if (5'(in_dev) < cnt_eff && !(dev_valid_q && sel_dev_q == DevW'(in_dev))) begin
              state_q   <= StSelRd;
              walk_q    <= '0;
              before_q  <= '0;
              after_q   <= '0;
              rd_pend_q <= 1'b0;
            end
          end
          jcss_pkg::CmdWrIr: begin
            if (dev_valid_q && cur_ir_q != in_val) begin
              cur_ir_q <= in_val;
              state_q  <= StTms;
            end
          end
          jcss_pkg::CmdDr: begin
            if (dev_valid_q) begin
              if (in_first) state_q <= StDrHead;
              else state_q <= StDrData;
            end
          end
          default: ;
        endcase
      end else begin
        case (state_q)
          StTrst: if (room) begin
            o_kind_q <= jcss_pkg::KindTrst; o_bits_q <= '0; o_data_q <= '0;
            o_exit_q <= 1'b0; o_cap_q <= 1'b0; o_last_q <= 1'b0;
            state_q  <= StExit; rem_q <= '1;
          end
          StSelRd: begin
            // memory walk: address walk_q issued, data next cycle
            rd_pend_q <= 1'b1;
            if (rd_pend_q) begin
              if (walk_q - DevW'(1) < cmd_dev_q)
                before_q <= before_q + SumW'(rdata);
              else if (walk_q - DevW'(1) == cmd_dev_q)
                sel_len_q <= rdata;
              else
                after_q <= after_q + SumW'(rdata);
            end
            if (5'(walk_q) + 5'd1 >= cnt_eff || walk_q == DevW'(jcss_pkg::MaxDevices - 1))
              state_q <= StSelSum;
            else
              walk_q <= walk_q + DevW'(1);
          end
          StSelSum: begin
            if (walk_q < cmd_dev_q)
              before_q <= before_q + SumW'(rdata);
            else if (walk_q == cmd_dev_q)
              sel_len_q <= rdata;
            else
              after_q <= after_q + SumW'(rdata);
            dev_valid_q <= 1'b1;
            sel_dev_q   <= cmd_dev_q;
            cur_ir_q    <= jcss_pkg::BypassIr;
            state_q     <= StIdle;
          end
          StTms: if (room) begin
            o_kind_q <= jcss_pkg::KindTms; o_bits_q <= 6'd4; o_data_q <= 32'h3;
            o_exit_q <= 1'b0; o_cap_q <= 1'b0; o_last_q <= 1'b0;
            rem_q <= before_q; state_q <= StPre;
          end
          StPre: if (rem_q == '0) state_q <= StTgt;
          else if (room) begin
            o_kind_q <= jcss_pkg::KindShift; o_bits_q <= chunk;
            o_data_q <= jcss_pkg::BypassIr; o_exit_q <= 1'b0; o_cap_q <= 1'b0;
            o_last_q <= 1'b0; rem_q <= rem_q - SumW'(chunk);
          end
          StTgt: if (room) begin
            o_kind_q <= jcss_pkg::KindShift; o_bits_q <= sel_len_q;
            o_data_q <= cur_ir_q; o_exit_q <= (after_q == '0); o_cap_q <= 1'b0;
            o_last_q <= 1'b0; rem_q <= after_q; state_q <= StPost;
          end
          StPost, StDrTail: if (rem_q == '0) state_q <= StExit;
          else if (room) begin
            o_kind_q <= jcss_pkg::KindShift; o_bits_q <= chunk;
            o_data_q <= (state_q == StPost) ? jcss_pkg::BypassIr : 32'd0;
            o_exit_q <= (rem_q <= SumW'(32)); o_cap_q <= 1'b0;
            o_last_q <= 1'b0; rem_q <= rem_q - SumW'(chunk);
          end
          StExit: if (room) begin
            // rem_q all ones marks the reset sequence
            o_kind_q <= jcss_pkg::KindTms; o_exit_q <= 1'b0; o_cap_q <= 1'b0;
            if (rem_q == '1) begin
              o_bits_q <= 6'd6; o_data_q <= 32'h1f; o_last_q <= 1'b1;
              dev_valid_q <= 1'b0; cur_ir_q <= jcss_pkg::BypassIr;
              state_q <= StIdle;
            end else begin
              o_bits_q <= 6'd2; o_data_q <= 32'h1; o_last_q <= (idle_eff == 6'd0);
              state_q <= (idle_eff == 6'd0) ? StIdle : StIdleClk;
            end
          end
          StIdleClk: if (room) begin
            o_kind_q <= jcss_pkg::KindTms; o_bits_q <= idle_eff; o_data_q <= '0;
            o_exit_q <= 1'b0; o_cap_q <= 1'b0; o_last_q <= 1'b1;
            state_q <= StIdle;
          end
          StDrHead: if (room) begin
            o_kind_q <= jcss_pkg::KindTms; o_bits_q <= 6'd3; o_data_q <= 32'h1;
            o_exit_q <= 1'b0; o_cap_q <= 1'b0; o_last_q <= 1'b0;
            rem_q <= SumW'(sel_dev_q); state_q <= StDrPad;
          end
          StDrPad: if (rem_q == '0) state_q <= StDrData;
          else if (room) begin
            o_kind_q <= jcss_pkg::KindShift; o_bits_q <= chunk; o_data_q <= '0;
            o_exit_q <= 1'b0; o_cap_q <= 1'b0; o_last_q <= 1'b0;
            rem_q <= rem_q - SumW'(chunk);
          end
          StDrData: if (room) begin
            o_kind_q <= jcss_pkg::KindShift; o_bits_q <= wbits_q; o_data_q <= val_q;
            o_exit_q <= last_q && tail_dev; o_cap_q <= 1'b1; o_last_q <= !last_q;
            rem_q <= tail_dev ? '0 : SumW'(cnt_eff - 5'(sel_dev_q) - 5'd1);
            state_q <= last_q ? StDrTail : StIdle;
          end
          default: state_q <= StIdle;
        endcase
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tdata  = {o_cap_q, o_exit_q, o_data_q, o_bits_q};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("segment changed under stall");
  a_cap_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_cap_q) |-> (o_kind_q == jcss_pkg::KindShift))
    else $error("capture on non-shift");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the jtag chain scan sequencer
// ----------------------------------------------------------------------------
// a directed table loads the ir length memory and walks every command and
// corner case, then random command sequences run under several chain
// settings. every word accepted on the output stream is compared field by
// field against a model of the sequencer kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSegs   = 20;
  localparam int unsigned DrainWait = 64;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  dev;
    logic [5:0]  irl;
    logic [31:0] val;
    logic [5:0]  wbits;
    logic        first;
    logic        last;
    logic        typed_reset;  // expectation typed in: trst + tms
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  bits;
    logic [31:0] data;
    logic        ex;
    logic        cap;
    logic        last;
  } seg_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [5:0]  cfg_wdata_i;

  jtag_chain_scan_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // chain model state
  logic [5:0]      irlen_mem [jcss_pkg::MaxDevices];
  logic            sel_valid;
  logic [4:0]      sel_dev;
  logic [31:0]     cur_ir;
  logic [5:0]      sel_len;
  logic [jcss_pkg::SumW-1:0] bits_before;
  logic [jcss_pkg::SumW-1:0] bits_after;
  logic [4:0]      chain_len;
  logic [5:0]      idle_len;

  seg_t      seg_q[$];   // segments still owed by the sequencer
  seg_t      scratch_q[$];
  int        errors;
  int        words_in;
  int        segs_out;
  int        burst_left;
  cmd_word_t dir_tbl[$];
  cmd_word_t pend_q[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // generous run limit
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned eff_chain();
    return (chain_len > jcss_pkg::MaxDevices) ? jcss_pkg::MaxDevices : chain_len;
  endfunction

  function automatic void add_seg(logic [1:0] k, int unsigned b, logic [31:0] d,
                                  logic ex, logic cap);
    if (scratch_q.size() < MaxSegs)
      scratch_q.push_back('{kind: k, bits: b[5:0], data: d, ex: ex, cap: cap, last: 1'b0});
  endfunction

  // split a long pad run into shift segments of 32 bits at most
  function automatic void add_pad(int unsigned total, logic [31:0] d, logic ex_end);
    int unsigned c;
    while (total != 0) begin
      c = (total <= 32) ? total : 32;
      total -= c;
      add_seg(jcss_pkg::KindShift, c, d, ex_end && total == 0, 1'b0);
    end
  endfunction

  // exit1 -> update -> idle, then idle clocks
  function automatic void add_idle();
    int unsigned n;
    n = (idle_len <= 32) ? idle_len : 32;
    add_seg(jcss_pkg::KindTms, 2, 32'h1, 1'b0, 1'b0);
    if (n != 0) add_seg(jcss_pkg::KindTms, n, 32'h0, 1'b0, 1'b0);
  endfunction

  // works out the segments of one command word into scratch_q
  function automatic void predict_segs(cmd_word_t w);
    int unsigned cnt;
    int unsigned sum;
    int unsigned wb;
    int unsigned lv;
    logic        tail_dev;
    cnt = eff_chain();
    scratch_q.delete();
    case (w.cmd)
      jcss_pkg::CmdReset: begin
        add_seg(jcss_pkg::KindTrst, 0, 32'h0, 1'b0, 1'b0);
        add_seg(jcss_pkg::KindTms, 6, 32'h1f, 1'b0, 1'b0);
        sel_valid = 1'b0;
        cur_ir    = jcss_pkg::BypassIr;
      end
      jcss_pkg::CmdLoad: begin
        lv = w.irl;
        if (lv == 0) lv = 1;
        if (lv > jcss_pkg::MaxIrLength) lv = jcss_pkg::MaxIrLength;
        irlen_mem[w.dev] = lv[5:0];
      end
      jcss_pkg::CmdSelect: begin
        if (w.dev < cnt && !(sel_valid && sel_dev == {1'b0, w.dev})) begin
          sel_valid = 1'b1;
          sel_dev   = {1'b0, w.dev};
          sel_len   = irlen_mem[w.dev];
          cur_ir    = jcss_pkg::BypassIr;
          sum = 0;
          for (int i = 0; i < w.dev; i++) sum += irlen_mem[i];
          bits_before = sum[jcss_pkg::SumW-1:0];
          sum = 0;
          for (int i = w.dev + 1; i < cnt; i++) sum += irlen_mem[i];
          bits_after = sum[jcss_pkg::SumW-1:0];
        end
      end
      jcss_pkg::CmdWrIr: begin
        if (sel_valid && cur_ir != w.val) begin
          cur_ir = w.val;
          add_seg(jcss_pkg::KindTms, 4, 32'h3, 1'b0, 1'b0);
          add_pad(bits_before, jcss_pkg::BypassIr, 1'b0);
          add_seg(jcss_pkg::KindShift, sel_len, w.val, bits_after == 0, 1'b0);
          add_pad(bits_after, jcss_pkg::BypassIr, 1'b1);
          add_idle();
        end
      end
      jcss_pkg::CmdDr: begin
        if (sel_valid) begin
          tail_dev = (sel_dev + 1 >= cnt);
          wb = w.wbits;
          if (wb == 0) wb = 1;
          if (wb > 32) wb = 32;
          if (w.first) begin
            add_seg(jcss_pkg::KindTms, 3, 32'h1, 1'b0, 1'b0);
            add_pad(sel_dev, 32'h0, 1'b0);
          end
          add_seg(jcss_pkg::KindShift, wb, w.val, w.last && tail_dev, 1'b1);
          if (w.last) begin
            if (!tail_dev) add_pad(cnt - sel_dev - 1, 32'h0, 1'b1);
            add_idle();
          end
        end
      end
      default: ;  // unknown command: nothing happens
    endcase
    if (scratch_q.size() > 0) scratch_q[scratch_q.size()-1].last = 1'b1;
  endfunction

  // push one command word; valid stays high inside a burst
  task automatic send_word(cmd_word_t w);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.cmd;
    s_axis_tlast  <= w.last;
    s_axis_tdata  <= {7'b0, w.first, w.wbits, w.val, w.irl, w.dev};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_segs(w);
    if (w.typed_reset) begin
      // reset is read straight off the spec: trst pulse, then a tms run of ones that ends in a zero
      seg_q.push_back('{kind: jcss_pkg::KindTrst, bits: 6'd0, data: 32'h0, ex: 1'b0,
                        cap: 1'b0, last: 1'b0});
      seg_q.push_back('{kind: jcss_pkg::KindTms, bits: 6'd6, data: 32'h1f, ex: 1'b0,
                        cap: 1'b0, last: 1'b1});
    end else begin
      foreach (scratch_q[i]) seg_q.push_back(scratch_q[i]);
    end
    words_in++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // drop valid, let every owed segment come out, then let a select finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [5:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == 1'b0) chain_len = v[4:0];
    else             idle_len  = v;
  endtask

  function automatic cmd_word_t noise_word();
    cmd_word_t w;
    w.cmd   = jcss_pkg::CmdLoad;
    w.dev   = 4'($urandom_range(0, 15));
    w.irl   = 6'($urandom_range(0, 63));
    w.val   = $urandom;
    w.wbits = 6'($urandom_range(0, 63));
    w.first = 1'($urandom_range(0, 1));
    w.last  = 1'($urandom_range(0, 1));
    w.typed_reset = 1'b0;
    return w;
  endfunction

  // builds one random command sequence into pend_q
  task automatic gen_sequence();
    cmd_word_t w;
    int unsigned r;
    int unsigned n;
    w = noise_word();
    r = $urandom_range(0, 99);
    if (!sel_valid && r < 70) r = 0;
    if (r < 10) begin
      w.cmd = jcss_pkg::CmdSelect;
      pend_q.push_back(w);
    end else if (r < 32) begin
      w.cmd = jcss_pkg::CmdWrIr;
      case ($urandom_range(0, 3))
        0: w.val = 32'hffff_fffe;
        1: w.val = cur_ir;          // unchanged: no segments
        default: ;
      endcase
      pend_q.push_back(w);
    end else if (r < 80) begin
      // well-formed dr scan of a few words
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        w = noise_word();
        w.cmd   = jcss_pkg::CmdDr;
        w.first = (i == 0);
        w.last  = (i == n - 1);
        if ($urandom_range(0, 3) != 0) w.wbits = 6'($urandom_range(1, 32));
        pend_q.push_back(w);
      end
    end else if (r < 86) begin
      pend_q.push_back(w);          // load, any length
    end else if (r < 90) begin
      w.cmd = jcss_pkg::CmdReset;
      pend_q.push_back(w);
    end else if (r < 93) begin
      w.cmd = 3'($urandom_range(5, 7));
      pend_q.push_back(w);
    end else begin
      w.cmd = jcss_pkg::CmdDr;      // dr word with random flags
      pend_q.push_back(w);
    end
  endtask

  function automatic cmd_word_t row(logic [2:0] c, logic [3:0] d, logic [5:0] l,
                                    logic [31:0] v, logic [5:0] b, logic f, logic la);
    return '{cmd: c, dev: d, irl: l, val: v, wbits: b, first: f, last: la,
             typed_reset: 1'b0};
  endfunction

  // output side: the stall pattern steps through four modes in turn
  int unsigned stall_cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cyc     <= 0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      case ((stall_cyc / 300) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 9) == 0);
        default: m_axis_tready <= (stall_cyc % 7 < 3);
      endcase
    end
  end

  // segment checker
  always @(posedge clk_i) begin
    seg_t got;
    seg_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, bits: m_axis_tdata[5:0], data: m_axis_tdata[37:6],
              ex: m_axis_tdata[38], cap: m_axis_tdata[39], last: m_axis_tlast};
      segs_out++;
      if (seg_q.size() == 0) begin
        $error("unexpected segment %h %h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = seg_q.pop_front();
        if (got.kind != want.kind) begin
          $error("seg_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
        end
        if (got.bits != want.bits) begin
          $error("seg_bits: expected %0d, got %0d", want.bits, got.bits); errors++;
        end
        if (got.data != want.data) begin
          $error("seg_data: expected %h, got %h", want.data, got.data); errors++;
        end
        if (got.ex != want.ex) begin
          $error("seg_exit: expected %0d, got %0d", want.ex, got.ex); errors++;
        end
        if (got.cap != want.cap) begin
          $error("capture_tdo: expected %0d, got %0d", want.cap, got.cap); errors++;
        end
        if (got.last != want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    cmd_word_t   rst_row;
    logic [4:0]  chain_set [6] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd9};
    logic [5:0]  idle_set  [6] = '{6'd32, 6'd63, 6'd3, 6'd1, 6'd7, 6'd0};

    errors = 0; words_in = 0; segs_out = 0; burst_left = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_wdata_i   = '0;
    for (int i = 0; i < jcss_pkg::MaxDevices; i++) irlen_mem[i] = '0;
    sel_valid = 1'b0; sel_dev = '0; cur_ir = jcss_pkg::BypassIr; sel_len = '0;
    bits_before = '0; bits_after = '0; chain_len = 5'd1; idle_len = '0;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part under a full chain with a couple of idle clocks
    write_cfg(1'b0, 6'd16);
    write_cfg(1'b1, 6'd2);

    rst_row = row(jcss_pkg::CmdReset, 4'd0, 6'd0, 32'h0, 6'd0, 1'b0, 1'b0);
    rst_row.typed_reset = 1'b1;
    dir_tbl.push_back(rst_row);
    // write ir with no device selected: ignored
    dir_tbl.push_back(row(jcss_pkg::CmdWrIr, 4'd0, 6'd0, 32'h1234_5678, 6'd0, 1'b0, 1'b0));
    // fill the ir length memory; zero becomes 1, 63 clamps to 32
    dir_tbl.push_back(row(jcss_pkg::CmdLoad, 4'd0, 6'd0, 32'h0, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdLoad, 4'd1, 6'd63, 32'h0, 6'd0, 1'b0, 1'b0));
    for (int d = 2; d < 16; d++)
      dir_tbl.push_back(row(jcss_pkg::CmdLoad, d[3:0],
                            (d == 7) ? 6'd1 : (d == 5) ? 6'd17 : 6'd32,
                            32'h0, 6'd0, 1'b0, 1'b0));
    // last device: long bypass run in front, nothing after
    dir_tbl.push_back(row(jcss_pkg::CmdSelect, 4'd15, 6'd0, 32'h0, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdWrIr, 4'd0, 6'd0, 32'hffff_fffe, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdDr, 4'd0, 6'd0, 32'hffff_ffff, 6'd0, 1'b1, 1'b1));
    // first device: long bypass run behind, dr padding after
    dir_tbl.push_back(row(jcss_pkg::CmdSelect, 4'd0, 6'd0, 32'h0, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdWrIr, 4'd0, 6'd0, 32'hffff_fffe, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdWrIr, 4'd0, 6'd0, 32'hffff_fffe, 6'd0, 1'b0, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdDr, 4'd0, 6'd0, 32'h0, 6'd32, 1'b1, 1'b0));
    dir_tbl.push_back(row(jcss_pkg::CmdDr, 4'd0, 6'd0, 32'ha5a5_5a5a, 6'd63, 1'b0, 1'b1));
    dir_tbl.push_back(row(3'd7, 4'd15, 6'd63, 32'hffff_ffff, 6'd63, 1'b1, 1'b1));
    foreach (dir_tbl[i]) send_word(dir_tbl[i]);
    drain();

    // random phases, device count and idle clocks changed between them
    for (int p = 0; p < 6; p++) begin
      write_cfg(1'b0, {1'b0, chain_set[p]});
      write_cfg(1'b1, idle_set[p]);
      sent = 0;
      while (sent < 73) begin
        gen_sequence();
        while (pend_q.size() > 0) begin
          send_word(pend_q.pop_front());
          sent++;
        end
      end
      drain();
    end

    $display("covered %0d command words and %0d segments over 7 chain settings",
             words_in, segs_out);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
